// File: hdl/srme_pkg.sv
// ---------------------------------------------------------------------------
// srme_pkg: shared types and codes of the sorted region map engine
// Request kinds, result codes, register indexes, controller states and the
// command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package srme_pkg;

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_REMOVE = 2'd1,
        K_LOOKUP = 2'd2,
        K_GAP    = 2'd3
    } t_kind;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_OVERLAP  = 3'd2;
    localparam logic [2:0] ST_NOSPACE  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic [7:0] CFG_USER_LOW  = 8'd0;
    localparam logic [7:0] CFG_USER_HIGH = 8'd1;
    localparam logic [7:0] CFG_KERNEL    = 8'd2;
    localparam logic [7:0] CFG_GAP_BASE  = 8'd3;

    localparam logic [31:0] RST_USER_LOW  = 32'h0000_1000;
    localparam logic [31:0] RST_USER_HIGH = 32'h8000_0000;
    localparam logic [31:0] RST_KERNEL    = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_GAP_BASE  = 32'h6000_0000;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] stop;
        logic [2:0]  prot;
        logic [7:0]  flags;
        logic [15:0] tag;
        logic [31:0] offset;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_FINAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic read;
        logic eval;
        logic final_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic check_fail;
        logic scan_end;
        logic eval_next;
        logic eval_final;
    } t_stat;

endpackage

`default_nettype wire

// File: hdl/srme_ctrl.sv
// ---------------------------------------------------------------------------
// srme_ctrl: sequencer of the region map engine
// Steps one request through check, scan and finish, and owns the output
// valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module srme_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  wire             i_ready,
    input  srme_pkg::t_stat i_stat,
    output srme_pkg::t_cmd  o_cmd
);
    import srme_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid;
    logic   w_free;

    assign w_free = !r_ovalid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CHECK;
            S_CHECK: n_state = i_stat.check_fail ? S_DONE : S_READ;
            S_READ:  n_state = i_stat.scan_end ? S_FINAL : S_EVAL;
            S_EVAL: begin
                if (i_stat.eval_next)       n_state = S_READ;
                else if (i_stat.eval_final) n_state = S_FINAL;
                else                        n_state = S_DONE;
            end
            S_FINAL: n_state = S_DONE;
            S_DONE:  if (w_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_valid;
        o_cmd.check      = (r_state == S_CHECK);
        o_cmd.read       = (r_state == S_READ) && !i_stat.scan_end;
        o_cmd.eval       = (r_state == S_EVAL);
        o_cmd.final_step = (r_state == S_FINAL);
        o_cmd.out_load   = (r_state == S_DONE) && w_free;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    // hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load)  r_ovalid <= 1'b1;
            else if (i_ready)    r_ovalid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/srme_dpath.sv
// ---------------------------------------------------------------------------
// srme_dpath: region table and request datapath
// Holds the sorted table, limit registers, the request being served and the
// output register; one table entry is evaluated per scan step.
// ---------------------------------------------------------------------------
`default_nettype none

module srme_dpath #(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_SHIFT  = 12
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_we,
    input  wire  [7:0]      i_cfg_idx,
    input  wire  [31:0]     i_cfg_data,
    input  wire  [1:0]      i_kind,
    input  wire  [31:0]     i_address,
    input  wire  [31:0]     i_length,
    input  wire  [2:0]      i_protection,
    input  wire  [7:0]      i_region_flags,
    input  wire  [15:0]     i_object_tag,
    input  wire  [31:0]     i_object_base,
    input  srme_pkg::t_cmd  i_cmd,
    output srme_pkg::t_stat o_stat,
    output logic [2:0]      o_status,
    output logic [31:0]     o_result_start,
    output logic [31:0]     o_result_end,
    output logic [2:0]      o_result_protection,
    output logic [7:0]      o_result_flags,
    output logic [15:0]     o_result_tag,
    output logic [31:0]     o_result_offset
);
    import srme_pkg::*;

    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int IW = $clog2(MAX_REGIONS + 1);
    localparam int PW = 35;
    localparam logic [PW-1:0] PMASK = {{(PW-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
    localparam logic [IW-1:0] MAXC = IW'(MAX_REGIONS);

    function automatic logic [PW-1:0] pg_up(input logic [PW-1:0] v);
        pg_up = (v + PMASK) & ~PMASK;
    endfunction

    // limit registers
    logic [31:0] r_low, r_high, r_kern, r_gbase;

    // request
    t_kind       r_kind;
    logic [31:0] r_a;
    logic        r_len_zero;
    logic [PW-1:0] r_s, r_e;
    logic [2:0]  r_prot;
    logic [7:0]  r_flags;
    logic [15:0] r_tag;
    logic [31:0] r_obase;

    // scan and result
    t_entry      r_tab [MAX_REGIONS];
    t_entry      n_tab [MAX_REGIONS];
    t_entry      r_cur;
    logic [IW-1:0] r_idx, r_pos, r_count;
    logic        r_removed;
    logic [2:0]  r_res;
    t_entry      r_rent;

    // evaluation signals
    logic [PW-1:0] w_cs, w_ce, w_rs, w_re, w_sum;
    logic        w_fail;
    logic        w_next, w_final;
    logic        w_ins, w_del, w_mod;
    logic [IW-1:0] w_ipos, w_mpos;
    t_entry      w_ient, w_ment;

    assign w_cs  = PW'(r_cur.start);
    assign w_ce  = PW'(r_cur.stop);
    assign w_rs  = (r_s > w_cs) ? r_s : w_cs;
    assign w_re  = (r_e < w_ce) ? r_e : w_ce;
    assign w_sum = r_s + r_e;

    // request checks
    always_comb begin
        w_fail = 1'b0;
        case (r_kind)
            K_ADD: w_fail = r_len_zero || (r_s < PW'(r_low)) || (r_e <= r_s)
                         || (r_e > PW'(r_high)) || (r_s >= PW'(r_kern))
                         || (r_e >= PW'(r_kern));
            K_REMOVE: w_fail = r_len_zero || (r_e <= r_s);
            K_GAP:    w_fail = (r_e == '0);
            default:  w_fail = 1'b0;
        endcase
    end

    // step decision and table edits
    always_comb begin
        w_next  = 1'b0;
        w_final = 1'b0;
        w_ins   = 1'b0;
        w_del   = 1'b0;
        w_mod   = 1'b0;
        w_ipos  = r_idx + IW'(1);
        w_mpos  = r_idx;
        w_ient  = r_cur;
        w_ment  = r_cur;
        if (i_cmd.eval) begin
            case (r_kind)
                K_ADD: begin
                    if (w_cs >= r_e)                           w_final = 1'b1;
                    else if (!((w_cs >= r_s) || (w_ce > r_s))) w_next  = 1'b1;
                end
                K_REMOVE: begin
                    if (w_cs >= r_e) begin
                        w_final = 1'b1;
                    end else if (w_re <= w_rs) begin
                        w_next = 1'b1;
                    end else if (w_rs == w_cs && w_re == w_ce) begin
                        w_del  = 1'b1;
                        w_next = 1'b1;
                    end else if (w_rs == w_cs) begin
                        w_mod = 1'b1;
                        w_ment.start  = w_re[31:0];
                        w_ment.offset = r_cur.offset + w_re[31:0] - w_rs[31:0];
                        w_next = 1'b1;
                    end else if (w_re == w_ce) begin
                        w_mod = 1'b1;
                        w_ment.stop = w_rs[31:0];
                        w_next = 1'b1;
                    end else if (r_count < MAXC) begin
                        // split: head keeps the front, tail opens behind it
                        w_mod = 1'b1;
                        w_ment.stop = w_rs[31:0];
                        w_ins = 1'b1;
                        w_ient.start  = w_re[31:0];
                        w_ient.offset = r_cur.offset + w_re[31:0] - w_cs[31:0];
                    end
                end
                K_LOOKUP: begin
                    if (w_cs > PW'(r_a))       w_final = 1'b1;
                    else if (!(PW'(r_a) < w_ce)) w_next = 1'b1;
                end
                default: begin
                    if (w_ce <= r_s)        w_next  = 1'b1;
                    else if (w_cs >= w_sum) w_final = 1'b1;
                    else                    w_next  = 1'b1;
                end
            endcase
        end else if (i_cmd.final_step && r_kind == K_ADD && r_count < MAXC) begin
            w_ins  = 1'b1;
            w_ipos = r_pos;
            w_ient.start  = r_s[31:0];
            w_ient.stop   = r_e[31:0];
            w_ient.prot   = r_prot;
            w_ient.flags  = r_flags;
            w_ient.tag    = r_tag;
            w_ient.offset = r_obase;
        end
    end

    // next table contents: shift open, shift closed, edit in place
    always_comb begin
        for (int j = 0; j < MAX_REGIONS; j++) n_tab[j] = r_tab[j];
        if (w_del) begin
            for (int j = 0; j < MAX_REGIONS - 1; j++)
                if (IW'(j) >= w_mpos) n_tab[j] = r_tab[j+1];
        end
        if (w_ins) begin
            for (int j = 1; j < MAX_REGIONS; j++)
                if (IW'(j) > w_ipos) n_tab[j] = r_tab[j-1];
            for (int j = 0; j < MAX_REGIONS; j++)
                if (IW'(j) == w_ipos) n_tab[j] = w_ient;
        end
        if (w_mod) begin
            for (int j = 0; j < MAX_REGIONS; j++)
                if (IW'(j) == w_mpos) n_tab[j] = w_ment;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_REGIONS; j++) r_tab[j] <= n_tab[j];
    end

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= RST_USER_LOW;
            r_high  <= RST_USER_HIGH;
            r_kern  <= RST_KERNEL;
            r_gbase <= RST_GAP_BASE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_USER_LOW:  r_low   <= i_cfg_data;
                CFG_USER_HIGH: r_high  <= i_cfg_data;
                CFG_KERNEL:    r_kern  <= i_cfg_data;
                CFG_GAP_BASE:  r_gbase <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_ins) begin
            r_count <= r_count + IW'(1);
        end else if (w_del) begin
            r_count <= r_count - IW'(1);
        end
    end

    // request and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= t_kind'(i_kind);
            r_a        <= i_address;
            r_len_zero <= (i_length == '0);
            r_prot     <= i_protection;
            r_flags    <= i_region_flags;
            r_tag      <= i_object_tag;
            r_obase    <= i_object_base;
            if (t_kind'(i_kind) == K_GAP) begin
                r_s <= pg_up(PW'(i_address));
                r_e <= pg_up(PW'(i_length));
            end else begin
                r_s <= PW'(i_address) & ~PMASK;
                r_e <= pg_up(PW'(i_address) + PW'(i_length));
            end
        end
        if (i_cmd.check) begin
            r_idx     <= '0;
            r_pos     <= '0;
            r_removed <= 1'b0;
            r_rent    <= '0;
            r_res     <= w_fail ? ST_INVALID : ST_OK;
            if (r_kind == K_GAP && r_s < PW'(r_gbase)) r_s <= PW'(r_gbase);
        end
        if (i_cmd.read) r_cur <= r_tab[r_idx[AW-1:0]];
        if (i_cmd.eval) begin
            case (r_kind)
                K_ADD: begin
                    if (!(w_cs >= r_e)) begin
                        if (w_next) begin
                            r_pos <= r_idx + IW'(1);
                            r_idx <= r_idx + IW'(1);
                        end else begin
                            r_res <= ST_OVERLAP;
                        end
                    end
                end
                K_REMOVE: begin
                    if (!(w_cs >= r_e) && !(w_re <= w_rs)) r_removed <= 1'b1;
                    if (w_next && !w_del) r_idx <= r_idx + IW'(1);
                    if (!w_next && !w_final)
                        r_res <= w_ins ? ST_OK : ST_NOSPACE;
                end
                K_LOOKUP: begin
                    if (w_next) r_idx <= r_idx + IW'(1);
                    else if (!w_final) r_rent <= r_cur;
                end
                default: begin
                    if (w_next) r_idx <= r_idx + IW'(1);
                    if (w_next && !(w_ce <= r_s)) r_s <= pg_up(w_ce);
                end
            endcase
        end
        if (i_cmd.final_step) begin
            case (r_kind)
                K_ADD:    r_res <= (r_count < MAXC) ? ST_OK : ST_NOSPACE;
                K_REMOVE: r_res <= r_removed ? ST_OK : ST_NOTFOUND;
                K_LOOKUP: r_res <= ST_NOTFOUND;
                default: begin
                    if (w_sum > PW'(r_high)) begin
                        r_res <= ST_NOSPACE;
                    end else begin
                        r_res <= ST_OK;
                        r_rent.start <= r_s[31:0];
                    end
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status            <= r_res;
            o_result_start      <= r_rent.start;
            o_result_end        <= r_rent.stop;
            o_result_protection <= r_rent.prot;
            o_result_flags      <= r_rent.flags;
            o_result_tag        <= r_rent.tag;
            o_result_offset     <= r_rent.offset;
        end
    end

    assign o_stat.check_fail = w_fail;
    assign o_stat.scan_end   = (r_idx >= r_count);
    assign o_stat.eval_next  = w_next;
    assign o_stat.eval_final = w_final;

endmodule

`default_nettype wire

// File: hdl/sorted_region_map_engine_unit.sv
// ---------------------------------------------------------------------------
// sorted_region_map_engine_unit: sorted region table engine
// Add, remove, lookup and gap search over a sorted table of page regions.
// ---------------------------------------------------------------------------
// One request at a time. A request is checked, then the scan visits N table
// entries (at most the entry count) before the finish step: each entry is
// first fetched into the compare register and then evaluated. Inserts,
// deletes and splits shift the whole table as it is written back. A
// finished result sits in the output register while the next request is
// taken.
`default_nettype none

module sorted_region_map_engine_unit #(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_SHIFT  = 12
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_kind,
    input  wire  [31:0] i_address,
    input  wire  [31:0] i_length,
    input  wire  [2:0]  i_protection,
    input  wire  [7:0]  i_region_flags,
    input  wire  [15:0] i_object_tag,
    input  wire  [31:0] i_object_base,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_result_start,
    output logic [31:0] o_result_end,
    output logic [2:0]  o_result_protection,
    output logic [7:0]  o_result_flags,
    output logic [15:0] o_result_tag,
    output logic [31:0] o_result_offset
);
    import srme_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    srme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    srme_dpath #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_kind              (i_kind),
        .i_address           (i_address),
        .i_length            (i_length),
        .i_protection        (i_protection),
        .i_region_flags      (i_region_flags),
        .i_object_tag        (i_object_tag),
        .i_object_base       (i_object_base),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .o_status            (o_status),
        .o_result_start      (o_result_start),
        .o_result_end        (o_result_end),
        .o_result_protection (o_result_protection),
        .o_result_flags      (o_result_flags),
        .o_result_tag        (o_result_tag),
        .o_result_offset     (o_result_offset)
    );

endmodule

`default_nettype wire
